// ===== rtl/core/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants of the region tile partitioner: request and
// response payloads, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rtp_pkg;

   // Default configuration of the top level.
   localparam int MAX_TILES_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;

   // The region is split into at most this many rows.
   localparam int ROWS_MAX = 4;

   // Field widths.
   localparam int FIELD_W   = 16;
   localparam int COUNT_W   = 7;
   localparam int POS_W     = 17;
   localparam int CELLS_W   = 48;
   localparam int ROW_W     = 2;
   localparam int COL_W     = 5;
   localparam int ROWS_W    = 3;
   localparam int DIVISOR_W = 5;
   localparam int AREA_W    = 32;

   typedef struct packed {
      logic [FIELD_W-1:0] offset_x;
      logic [FIELD_W-1:0] offset_y;
      logic [FIELD_W-1:0] region_width;
      logic [FIELD_W-1:0] region_height;
      logic [FIELD_W-1:0] region_days;
      logic [COUNT_W-1:0] tile_count;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   tile_x;
      logic [POS_W-1:0]   tile_y;
      logic [FIELD_W-1:0] tile_width;
      logic [FIELD_W-1:0] tile_height;
      logic [FIELD_W-1:0] tile_days;
      logic [CELLS_W-1:0] tile_cells;
      logic [ROW_W-1:0]   tile_row;
      logic [COL_W-1:0]   tile_col;
      logic               tile_valid;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ZERO,
      ST_DIV_Y,
      ST_ROW,
      ST_DIV_X,
      ST_SIZE,
      ST_MUL1,
      ST_MUL2,
      ST_PUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_y;
      logic take_y;
      logic div_x;
      logic take_x;
      logic size;
      logic mul1;
      logic mul2;
      logic push_tile;
      logic push_zero;
      logic next_col;
      logic next_row;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic div_busy;
      logic div_done;
      logic last_row;
      logic last_col;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/region_tile_partitioner_core.sv =====
// ----------------------------------------------------------------------------
// region_tile_partitioner_core
// Splits a 2D region into up to MAX_TILES tiles over at most four rows and
// returns one response per tile.
// ----------------------------------------------------------------------------
// Usage: a request on req_* carries the region origin, extent, day count and
// tile count. It is taken when req_valid and req_ready are high together.
// The block then returns one response per tile on rsp_*, row by row and
// column by column, with last set on the final one. A tile count of zero
// gives one response with tile_valid low and last high.
// Sequencing: a shared one-bit-per-cycle divider divides the height once and
// the width once per row. Each tile then steps through size, two multiply
// steps and the output load.
// req_ready is high only while no request is in progress; the next request
// can be taken while the last response still waits in the output register.
// When the receiver stalls, the tile walk pauses at the output register.
// Reset returns the controller to idle and empties the output register.
// ----------------------------------------------------------------------------
module region_tile_partitioner_core #(
   parameter int MAX_TILES  = rtp_pkg::MAX_TILES_DEF,
   parameter int COORD_BITS = rtp_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rtp_pkg::rsp_type rsp_data
);

   rtp_pkg::cmd_type    cmd;
   rtp_pkg::status_type sts;

   // Sequencing.
   rtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   rtp_datapath #(
      .MAX_TILES  (MAX_TILES),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/rtp_div.sv =====
// ----------------------------------------------------------------------------
// rtp_div
// Restoring divider for a wide dividend and a narrow divisor, one quotient
// bit per cycle. Quotient and remainder are valid when done pulses.
// ----------------------------------------------------------------------------
module rtp_div #(
   parameter int DIVIDEND_W = rtp_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIVIDEND_W-1:0]          dividend,
   input  logic [rtp_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic                           done,
   output logic [DIVIDEND_W-1:0]          quotient,
   output logic [rtp_pkg::DIVISOR_W-1:0]  remainder
);

   localparam int DW    = rtp_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DW:0]           trial;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DW'(trial - {1'b0, dvs_ff}) : DW'(trial);
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Control registers are reset; the operands are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/rtp_datapath.sv =====
// ----------------------------------------------------------------------------
// rtp_datapath
// Request latch, row and column counters, the shared divider, the tile size
// and cell count arithmetic, and the response output register.
// ----------------------------------------------------------------------------
module rtp_datapath #(
   parameter int MAX_TILES  = rtp_pkg::MAX_TILES_DEF,
   parameter int COORD_BITS = rtp_pkg::COORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rtp_pkg::req_type    req_data,
   input  rtp_pkg::cmd_type    cmd,
   output rtp_pkg::status_type sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rtp_pkg::rsp_type    rsp_data
);

   localparam int CW  = COORD_BITS;
   localparam int FW  = rtp_pkg::FIELD_W;
   localparam int PW  = rtp_pkg::POS_W;
   localparam int NW  = rtp_pkg::COUNT_W;
   localparam int RW  = rtp_pkg::ROW_W;
   localparam int KW  = rtp_pkg::COL_W;
   localparam int SW  = rtp_pkg::ROWS_W;
   localparam int DW  = rtp_pkg::DIVISOR_W;
   localparam int AW  = rtp_pkg::AREA_W;
   localparam int XW  = rtp_pkg::CELLS_W;

   // Latched request.
   logic [CW-1:0] ox_ff, oy_ff, rw_ff, rh_ff;
   logic [FW-1:0] rd_ff;
   logic [NW-1:0] count_ff, count_in;

   // Split geometry.
   logic [SW-1:0] rows;
   logic [KW-1:0] base_cols;
   logic [RW-1:0] extra_rows;
   logic [KW-1:0] cols_cur;

   // Walk state and per-row results.
   logic [CW-1:0] qy_ff, qx_ff;
   logic [DW-1:0] ry_ff, rx_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [KW-1:0] col_ff, col_in;
   logic [PW-1:0] x_acc_ff, x_acc_in;
   logic [PW-1:0] y_acc_ff, y_acc_in;
   logic [FW-1:0] w_ff, h_ff;
   logic [CW:0]   w_sum, h_sum;
   logic [AW-1:0] hw_ff;
   logic [XW-1:0] cells_ff;
   logic          last_row, last_col;

   // Divider hookup.
   logic          div_start;
   logic [CW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_busy, div_done;
   logic [CW-1:0] div_quo;
   logic [DW-1:0] div_rem;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rtp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             out_free;

   // Tile count saturates at the configured maximum.
   assign count_in = (req_data.tile_count > NW'(MAX_TILES)) ? NW'(MAX_TILES)
                                                            : req_data.tile_count;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ox_ff    <= CW'(req_data.offset_x);
         oy_ff    <= CW'(req_data.offset_y);
         rw_ff    <= CW'(req_data.region_width);
         rh_ff    <= CW'(req_data.region_height);
         rd_ff    <= req_data.region_days;
         count_ff <= count_in;
      end
   end

   // Rows and columns: one tile per row up to the row limit, then the count
   // is spread over the rows with the leading rows taking one extra column.
   always_comb begin
      if (count_ff <= NW'(rtp_pkg::ROWS_MAX)) begin
         rows       = SW'(count_ff);
         base_cols  = KW'(1);
         extra_rows = '0;
      end else begin
         rows       = SW'(rtp_pkg::ROWS_MAX);
         base_cols  = KW'(count_ff / rtp_pkg::ROWS_MAX);
         extra_rows = RW'(count_ff % rtp_pkg::ROWS_MAX);
      end
   end

   assign cols_cur = base_cols + KW'(row_ff < extra_rows);
   assign last_row = ({1'b0, row_ff} == rows - SW'(1));
   assign last_col = (col_ff == cols_cur - KW'(1));

   // Shared divider: height by rows once, then width by columns per row.
   assign div_start    = cmd.div_y | cmd.div_x;
   assign div_dividend = cmd.div_y ? rh_ff : rw_ff;
   assign div_divisor  = cmd.div_y ? DW'(rows) : cols_cur;

   rtp_div #(
      .DIVIDEND_W (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.take_y) begin
         qy_ff <= div_quo;
         ry_ff <= div_rem;
      end
      if (cmd.take_x) begin
         qx_ff <= div_quo;
         rx_ff <= div_rem;
      end
   end

   // Row and column counters with the running tile origin.
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      if (cmd.take_y) begin
         row_in   = '0;
         y_acc_in = PW'(oy_ff);
      end else if (cmd.next_row) begin
         row_in   = row_ff + RW'(1);
         y_acc_in = y_acc_ff + PW'(qy_ff);
      end
      if (cmd.take_x) begin
         col_in   = '0;
         x_acc_in = PW'(ox_ff);
      end else if (cmd.next_col) begin
         col_in   = col_ff + KW'(1);
         x_acc_in = x_acc_ff + PW'(qx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      x_acc_ff <= x_acc_in;
      y_acc_ff <= y_acc_in;
   end

   // Tile size: the last column and the last row take the remainders.
   assign w_sum = (CW+1)'(qx_ff) + (last_col ? (CW+1)'(rx_ff) : '0);
   assign h_sum = (CW+1)'(qy_ff) + (last_row ? (CW+1)'(ry_ff) : '0);

   // Size, then area, then cell count, one register after each step.
   always_ff @(posedge clock) begin
      if (cmd.size) begin
         w_ff <= FW'(w_sum);
         h_ff <= FW'(h_sum);
      end
      if (cmd.mul1) begin
         hw_ff <= AW'(w_ff) * AW'(h_ff);
      end
      if (cmd.mul2) begin
         cells_ff <= XW'(hw_ff) * XW'(rd_ff);
      end
   end

   // Output register: loads when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push_tile) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.tile_x      = x_acc_ff;
         rsp_data_in.tile_y      = y_acc_ff;
         rsp_data_in.tile_width  = w_ff;
         rsp_data_in.tile_height = h_ff;
         rsp_data_in.tile_days   = rd_ff;
         rsp_data_in.tile_cells  = cells_ff;
         rsp_data_in.tile_row    = row_ff;
         rsp_data_in.tile_col    = col_ff;
         rsp_data_in.tile_valid  = 1'b1;
         rsp_data_in.last        = last_row && last_col;
      end else if (cmd.push_zero) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.last        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status back to the controller.
   assign sts.count_zero = (count_ff == '0);
   assign sts.div_busy   = div_busy;
   assign sts.div_done   = div_done;
   assign sts.last_row   = last_row;
   assign sts.last_col   = last_col;
   assign sts.out_free   = out_free;

endmodule

// ===== rtl/core/rtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtp_ctrl
// Controller state machine: accepts a request, sequences the divisions and
// walks the tiles row by row, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module rtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rtp_pkg::status_type sts,
   output rtp_pkg::cmd_type    cmd
);

   rtp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rtp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rtp_pkg::ST_CHECK;
            end
         end
         rtp_pkg::ST_CHECK: begin
            if (sts.count_zero) begin
               state_in = rtp_pkg::ST_ZERO;
            end else begin
               cmd.div_y = 1'b1;
               state_in  = rtp_pkg::ST_DIV_Y;
            end
         end
         rtp_pkg::ST_ZERO: begin
            if (sts.out_free) begin
               cmd.push_zero = 1'b1;
               state_in      = rtp_pkg::ST_IDLE;
            end
         end
         rtp_pkg::ST_DIV_Y: begin
            if (sts.div_done) begin
               cmd.take_y = 1'b1;
               state_in   = rtp_pkg::ST_ROW;
            end
         end
         rtp_pkg::ST_ROW: begin
            cmd.div_x = 1'b1;
            state_in  = rtp_pkg::ST_DIV_X;
         end
         rtp_pkg::ST_DIV_X: begin
            if (sts.div_done) begin
               cmd.take_x = 1'b1;
               state_in   = rtp_pkg::ST_SIZE;
            end
         end
         rtp_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = rtp_pkg::ST_MUL1;
         end
         rtp_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = rtp_pkg::ST_MUL2;
         end
         rtp_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = rtp_pkg::ST_PUSH;
         end
         rtp_pkg::ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push_tile = 1'b1;
               if (!sts.last_col) begin
                  cmd.next_col = 1'b1;
                  state_in     = rtp_pkg::ST_SIZE;
               end else if (!sts.last_row) begin
                  cmd.next_row = 1'b1;
                  state_in     = rtp_pkg::ST_ROW;
               end else begin
                  state_in     = rtp_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rtp_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // A response is only loaded when the output register can take it.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_tile || cmd.push_zero) |-> sts.out_free)
      else $error("response pushed into a full output register");

   // The divider is never restarted while it is still working.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_y || cmd.div_x) |-> !sts.div_busy)
      else $error("divider started while busy");

   // The final tile of a request returns the controller to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_tile && sts.last_row && sts.last_col) |=> state_ff == rtp_pkg::ST_IDLE)
      else $error("controller did not return to idle after the last tile");

   // The empty answer is only given for a zero tile count.
   a_zero_only: assert property (@(posedge clock) disable iff (reset)
      cmd.push_zero |-> sts.count_zero)
      else $error("empty answer for a nonzero tile count");
`endif

endmodule
